FILE: sv/drive_command_frame_refresher_unit_assert.svh
`ifndef DRIVE_COMMAND_FRAME_REFRESHER_UNIT_ASSERT_SVH
`define DRIVE_COMMAND_FRAME_REFRESHER_UNIT_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define DCFR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DCFR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/dcfr_pkg.sv
package dcfr_pkg;

    // Item kinds
    localparam logic [1:0] FUNC_DIFF = 2'd0;
    localparam logic [1:0] FUNC_DIR  = 2'd1;
    localparam logic [1:0] FUNC_TICK = 2'd2;

    // Direction codes
    localparam logic [2:0] DIR_STOP     = 3'd0;
    localparam logic [2:0] DIR_FORWARD  = 3'd1;
    localparam logic [2:0] DIR_BACKWARD = 3'd2;
    localparam logic [2:0] DIR_LEFT     = 3'd3;
    localparam logic [2:0] DIR_RIGHT    = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_STOP_RESEND = 2'd0;
    localparam logic [1:0] CFG_PIVOT_SPEED = 2'd1;
    localparam logic [1:0] CFG_STEER_GAIN  = 2'd2;

    localparam logic [3:0] STOP_RESEND_RST = 4'd4;
    localparam logic [6:0] PIVOT_SPEED_RST = 7'd40;
    localparam logic [2:0] STEER_GAIN_RST  = 3'd3;

    localparam logic [7:0] FRAME_HEAD = 8'hAA;
    localparam logic [7:0] FRAME_TAIL = 8'hBB;

    localparam logic signed [12:0] CLAMP_MAX = 13'sd100;
    localparam logic signed [7:0]  TURN_STEER = 8'sd100;

    typedef struct packed {
        logic signed [7:0] motor;
        logic signed [7:0] steer;
    } target_t;

    typedef enum logic [2:0] {
        POS_HEAD,
        POS_MOTOR,
        POS_STEER_A,
        POS_STEER_B,
        POS_TAIL
    } pos_t;

    function automatic logic signed [7:0] clamp100(input logic signed [12:0] v);
        logic signed [7:0] r;
        if (v > CLAMP_MAX) begin
            r = 8'(CLAMP_MAX);
        end else if (v < -CLAMP_MAX) begin
            r = 8'(-CLAMP_MAX);
        end else begin
            r = v[7:0];
        end
        return r;
    endfunction

endpackage

FILE: sv/dcfr_ifs.sv
interface dcfr_cmd_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic signed [7:0] left;
    logic signed [7:0] right;
    logic [2:0]        dir;
    logic signed [7:0] speed;

    modport source (output valid, output func, output left, output right,
                    output dir, output speed, input ready);
    modport sink   (input valid, input func, input left, input right,
                    input dir, input speed, output ready);
endinterface

interface dcfr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, output tx_byte, output frame_end, input ready);
    modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface

FILE: sv/dcfr_mixer.sv
module dcfr_mixer (
    input  logic [1:0]        func,
    input  logic signed [7:0] left,
    input  logic signed [7:0] right,
    input  logic [2:0]        dir,
    input  logic signed [7:0] speed,
    input  logic [6:0]        pivot_speed,
    input  logic [2:0]        steer_gain,
    output dcfr_pkg::target_t target
);
    import dcfr_pkg::*;

    logic signed [8:0]  sum;
    logic signed [8:0]  half;
    logic signed [8:0]  diff;
    logic signed [12:0] diff_steer;
    logic signed [9:0]  diff_motor;
    logic signed [7:0]  speed_neg;
    logic signed [9:0]  dir_motor;
    logic signed [12:0] dir_steer;
    logic signed [9:0]  motor;
    logic signed [12:0] steer;
    logic signed [12:0] motor_neg;

    // Differential mix: average truncated toward zero, gain on the difference
    always_comb
    begin
        sum        = 9'(left) + 9'(right);
        half       = (sum + $signed({8'd0, sum[8]})) >>> 1;
        diff       = 9'(right) - 9'(left);
        diff_steer = 13'(diff) * $signed({10'd0, steer_gain});
        if (half == 9'sd0 && diff_steer != 13'sd0) begin
            diff_motor = $signed({3'd0, pivot_speed});
        end else begin
            diff_motor = 10'(half);
        end
    end

    // Direction command; reverse wraps in 8 bits
    always_comb
    begin
        speed_neg = -speed;
        dir_motor = 10'sd0;
        dir_steer = 13'sd0;
        case (dir)
            DIR_FORWARD:  dir_motor = 10'(speed);
            DIR_BACKWARD: dir_motor = 10'(speed_neg);
            DIR_LEFT:
            begin
                dir_motor = 10'(speed);
                dir_steer = 13'(TURN_STEER);
            end
            DIR_RIGHT:
            begin
                dir_motor = 10'(speed);
                dir_steer = -13'(TURN_STEER);
            end
            default:
            begin
                dir_motor = 10'sd0;
                dir_steer = 13'sd0;
            end
        endcase
    end

    always_comb
    begin
        if (func == FUNC_DIFF) begin
            motor = diff_motor;
            steer = diff_steer;
        end else begin
            motor = dir_motor;
            steer = dir_steer;
        end
        motor_neg    = -13'(motor);
        target.motor = clamp100(motor_neg);
        target.steer = clamp100(steer);
    end

endmodule

FILE: sv/dcfr_framer.sv
module dcfr_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               launch_valid,
    output logic               launch_ready,
    input  dcfr_pkg::target_t  launch_target,
    dcfr_byte_if.source        tx
);
    import dcfr_pkg::*;

    logic    busy_reg;
    logic    busy_next;
    pos_t    pos_reg;
    pos_t    pos_next;
    target_t frame_reg;
    logic    xfer;
    logic    load;

    assign xfer         = tx.valid && tx.ready;
    assign launch_ready = !busy_reg || (xfer && pos_reg == POS_TAIL);
    assign load         = launch_valid && launch_ready;

    // Next state: advance one byte per transfer, reload after the trailer
    always_comb
    begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (load) begin
            busy_next = 1'b1;
            pos_next  = POS_HEAD;
        end else if (xfer) begin
            case (pos_reg)
                POS_HEAD:    pos_next = POS_MOTOR;
                POS_MOTOR:   pos_next = POS_STEER_A;
                POS_STEER_A: pos_next = POS_STEER_B;
                POS_STEER_B: pos_next = POS_TAIL;
                POS_TAIL:    busy_next = 1'b0;
                default:     busy_next = 1'b0;
            endcase
        end
    end

    // Outputs
    always_comb
    begin
        tx.valid     = busy_reg;
        tx.frame_end = 1'b0;
        case (pos_reg)
            POS_HEAD:    tx.tx_byte = FRAME_HEAD;
            POS_MOTOR:   tx.tx_byte = frame_reg.motor;
            POS_STEER_A: tx.tx_byte = frame_reg.steer;
            POS_STEER_B: tx.tx_byte = frame_reg.steer;
            POS_TAIL:
            begin
                tx.tx_byte   = FRAME_TAIL;
                tx.frame_end = 1'b1;
            end
            default:     tx.tx_byte = FRAME_TAIL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            pos_reg  <= POS_HEAD;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            frame_reg <= launch_target;
        end
    end

endmodule

FILE: sv/drive_command_frame_refresher_unit.sv
// Channel | Dir | Payload                          | Transfer
// --------+-----+----------------------------------+------------------------
// cmd     | in  | func, left, right, dir, speed    | valid & ready at clk rise
// tx      | out | tx_byte, frame_end               | valid & ready at clk rise
// cfg     | in  | cfg_index, cfg_data              | cfg_we at clk rise
//
// An item that sends a frame occupies the framer for its five bytes, one byte per
// transfer; that serializer sets the sustained rate. An item that sends
// nothing passes the input register without waiting for the framer. The
// first frame byte shows once the framer loads the item from the input register;
// the next item is taken while the trailer of the previous frame is transferred.
// Reset clears the target, the stop resend count and all valid flags, and
// loads the configuration registers with their defaults. A stall on tx holds
// the current byte and backs up into cmd through the input register.
module drive_command_frame_refresher_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [6:0] cfg_data,
    dcfr_cmd_if.sink   cmd,
    dcfr_byte_if.source tx
);
    import dcfr_pkg::*;

    // Configuration registers
    logic [3:0] stop_resend_reg;
    logic [6:0] pivot_speed_reg;
    logic [2:0] steer_gain_reg;

    // Input register
    logic              in_valid_reg;
    logic [1:0]        func_reg;
    logic signed [7:0] left_reg;
    logic signed [7:0] right_reg;
    logic [2:0]        dir_reg;
    logic signed [7:0] speed_reg;

    // Drive target and stop resend state
    target_t    target_reg;
    target_t    target_next;
    logic [3:0] sends_left_reg;
    logic [3:0] sends_left_next;

    target_t    mixed;
    logic       is_cmd;
    logic       is_tick;
    logic       moving;
    logic [3:0] count_base;
    logic       send;
    logic       launch_ready;
    logic       advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stop_resend_reg <= STOP_RESEND_RST;
            pivot_speed_reg <= PIVOT_SPEED_RST;
            steer_gain_reg  <= STEER_GAIN_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_STOP_RESEND: stop_resend_reg <= cfg_data[3:0];
                CFG_PIVOT_SPEED: pivot_speed_reg <= cfg_data;
                CFG_STEER_GAIN:  steer_gain_reg  <= cfg_data[2:0];
                default:         ;
            endcase
        end
    end

    // Take a new item when empty or when the held one moves on this cycle
    assign cmd.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (cmd.ready) begin
            in_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready) begin
            func_reg  <= cmd.func;
            left_reg  <= cmd.left;
            right_reg <= cmd.right;
            dir_reg   <= cmd.dir;
            speed_reg <= cmd.speed;
        end
    end

    dcfr_mixer u_mixer (
        .func        (func_reg),
        .left        (left_reg),
        .right       (right_reg),
        .dir         (dir_reg),
        .speed       (speed_reg),
        .pivot_speed (pivot_speed_reg),
        .steer_gain  (steer_gain_reg),
        .target      (mixed)
    );

    // A command replaces the target and rearms or clears the resend count;
    // a tick keeps the target. A stop target spends one resend per send
    // decision. The unused item kind changes nothing and sends nothing.
    always_comb
    begin
        is_cmd  = (func_reg == FUNC_DIFF) || (func_reg == FUNC_DIR);
        is_tick = (func_reg == FUNC_TICK);
        target_next = is_cmd ? mixed : target_reg;
        moving = (target_next.motor != 8'sd0) || (target_next.steer != 8'sd0);
        if (is_cmd) begin
            count_base = moving ? 4'd0 : stop_resend_reg;
        end else begin
            count_base = sends_left_reg;
        end
        send = is_cmd || (is_tick && (moving || count_base != 4'd0));
        if (!is_cmd && !is_tick) begin
            sends_left_next = sends_left_reg;
        end else if (!moving && count_base != 4'd0) begin
            sends_left_next = count_base - 4'd1;
        end else begin
            sends_left_next = count_base;
        end
    end

    // Hold the item until the framer has room for its frame
    assign advance = in_valid_reg && (!send || launch_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            target_reg     <= '0;
            sends_left_reg <= 4'd0;
        end else if (advance) begin
            target_reg     <= target_next;
            sends_left_reg <= sends_left_next;
        end
    end

    dcfr_framer u_framer (
        .clk           (clk),
        .rst_n         (rst_n),
        .launch_valid  (in_valid_reg && send),
        .launch_ready  (launch_ready),
        .launch_target (target_next),
        .tx            (tx)
    );

`include "drive_command_frame_refresher_unit_assert.svh"

    `DCFR_ASSERT_NOW(a_target_range,
        1'b1,
        target_reg.motor <= 8'sd100 && target_reg.motor >= -8'sd100 &&
        target_reg.steer <= 8'sd100 && target_reg.steer >= -8'sd100,
        "stored target outside clamp range")

    `DCFR_ASSERT_NOW(a_moving_no_resend,
        target_reg.motor != 8'sd0 || target_reg.steer != 8'sd0,
        sends_left_reg == 4'd0,
        "resend count armed while target is moving")

    `DCFR_ASSERT_NEXT(a_frame_unbroken,
        tx.valid && tx.ready && !tx.frame_end,
        tx.valid,
        "frame interrupted before its trailer")

    `DCFR_ASSERT_NEXT(a_send_starts_frame,
        in_valid_reg && send && launch_ready,
        tx.valid && tx.tx_byte == FRAME_HEAD,
        "launched frame did not open with its header")

endmodule

FILE: tb/tb_top.sv
module tb_top;
    import dcfr_pkg::*;

    // Codes the package leaves unnamed: the ignored item kind and the spare
    // direction codes that fall back to stop.
    localparam logic [1:0] FUNC_SPARE   = 2'd3;
    localparam logic [2:0] DIR_UNUSED_A = 3'd5;
    localparam logic [2:0] DIR_UNUSED_B = 3'd6;
    localparam logic [2:0] DIR_UNUSED_C = 3'd7;

    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 30;
    localparam int HOLD_BURST     = 16;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int LIMIT_CYCLES   = 400000;

    typedef struct {
        logic [1:0]        func;
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic [2:0]        dir;
        logic signed [7:0] speed;
    } drive_cmd_t;

    // How a directed row is checked: by the predictor, against a frame typed
    // into the table, or as a row that must not produce a frame.
    typedef enum logic [1:0] {
        CHECK_PREDICTED,
        CHECK_FRAME,
        CHECK_SILENT
    } row_check_e;

    typedef struct {
        drive_cmd_t cmd;
        row_check_e check;
        logic [7:0] motor;
        logic [7:0] steer;
    } directed_row_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    dcfr_cmd_if  cmd_ch ();
    dcfr_byte_if tx_ch ();

    drive_command_frame_refresher_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd_ch),
        .tx        (tx_ch)
    );

    // Shadow of the configuration registers, loaded with the reset defaults.
    logic [3:0] resend_setting = STOP_RESEND_RST;
    logic [6:0] pivot_setting  = PIVOT_SPEED_RST;
    logic [2:0] gain_setting   = STEER_GAIN_RST;

    // Shadow of the stored target and the stop resend counter.
    logic signed [7:0] tgt_motor         = '0;
    logic signed [7:0] tgt_steer         = '0;
    logic [3:0]        stop_repeats_left = '0;

    frame_byte_t pending_bytes[$];
    int          mismatches  = 0;
    int          cycle_count = 0;
    bit          no_idle     = 1'b0;
    bit          rx_hold_req = 1'b0;

    // Directed stimulus. Rows run right after reset with the default
    // registers (resend 4, pivot 40, gain 3); the typed frames depend on it.
    directed_row_t directed_rows [0:24] = '{
        // tick after reset: stop target, no resends armed, nothing goes out
        '{'{FUNC_TICK, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_SILENT, 8'h00, 8'h00},
        // stop command sends now and arms three more sends
        '{'{FUNC_DIFF, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'h00, 8'h00},
        '{'{FUNC_TICK, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'h00, 8'h00},
        '{'{FUNC_TICK, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'h00, 8'h00},
        '{'{FUNC_TICK, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'h00, 8'h00},
        // resends used up: the tick goes silent
        '{'{FUNC_TICK, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_SILENT, 8'h00, 8'h00},
        // full forward and full reverse clamp to -100 and +100 after negation
        '{'{FUNC_DIFF, 8'sd127, 8'sd127, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'h9C, 8'h00},
        '{'{FUNC_DIFF, 8'sh80, 8'sh80, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'h64, 8'h00},
        // opposite extremes: average truncates to zero, pivot speed takes over
        '{'{FUNC_DIFF, 8'sh80, 8'sd127, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'hD8, 8'h64},
        '{'{FUNC_DIFF, 8'sd127, 8'sh80, DIR_STOP, 8'sd0}, CHECK_FRAME, 8'hD8, 8'h9C},
        '{'{FUNC_DIFF, 8'sd1, 8'sd0, DIR_STOP, 8'sd0}, CHECK_PREDICTED, 8'h00, 8'h00},
        // moving target: a tick resends it
        '{'{FUNC_TICK, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_PREDICTED, 8'h00, 8'h00},
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_FORWARD, 8'sd127}, CHECK_FRAME, 8'h9C, 8'h00},
        // backward at -128 wraps to -128 before negation
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_BACKWARD, 8'sh80}, CHECK_FRAME, 8'h64, 8'h00},
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_BACKWARD, 8'sd50}, CHECK_PREDICTED, 8'h00, 8'h00},
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_LEFT, 8'sh80}, CHECK_FRAME, 8'h64, 8'h64},
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_RIGHT, 8'sd0}, CHECK_FRAME, 8'h00, 8'h9C},
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_STOP, 8'sd99}, CHECK_PREDICTED, 8'h00, 8'h00},
        // ignored item kind: no state change, no frame
        '{'{FUNC_SPARE, 8'sd127, 8'sh80, DIR_UNUSED_C, -8'sd1}, CHECK_SILENT, 8'h00, 8'h00},
        '{'{FUNC_TICK, 8'sd0, 8'sd0, DIR_STOP, 8'sd0}, CHECK_PREDICTED, 8'h00, 8'h00},
        // spare direction codes act as stop
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_UNUSED_A, 8'sd10}, CHECK_PREDICTED, 8'h00, 8'h00},
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_UNUSED_C, -8'sd1}, CHECK_PREDICTED, 8'h00, 8'h00},
        '{'{FUNC_DIR, 8'sd0, 8'sd0, DIR_UNUSED_B, 8'sd127}, CHECK_PREDICTED, 8'h00, 8'h00},
        '{'{FUNC_DIFF, -8'sd1, 8'sd1, DIR_STOP, 8'sd0}, CHECK_PREDICTED, 8'h00, 8'h00},
        '{'{FUNC_DIFF, 8'sd100, -8'sd100, DIR_STOP, 8'sd0}, CHECK_PREDICTED, 8'h00, 8'h00}
    };

    // Free-running clock, 12 units per period.
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    function automatic logic signed [7:0] limit_pm100(input int v);
        if (v > 100) return 8'sd100;
        if (v < -100) return -8'sd100;
        return 8'(v);
    endfunction

    // Advance the shadow target for one accepted item. Return 1 when the item
    // sends a frame, with the motor and steer bytes that go out.
    function automatic bit advance_drive_target(input drive_cmd_t c,
                                                output logic [7:0] motor_b,
                                                output logic [7:0] steer_b);
        int                mot;
        int                st;
        logic signed [7:0] wrapped;
        bit                fresh;
        bit                moving;
        bit                sends;

        mot   = 0;
        st    = 0;
        fresh = 1'b1;
        motor_b = 8'h00;
        steer_b = 8'h00;
        case (c.func)
            FUNC_DIFF:
            begin
                mot = (int'(c.left) + int'(c.right)) / 2;
                st  = (int'(c.right) - int'(c.left)) * int'(gain_setting);
                if (mot == 0 && st != 0)
                    mot = int'(pivot_setting);
            end
            FUNC_DIR:
            begin
                case (c.dir)
                    DIR_FORWARD: mot = c.speed;
                    DIR_BACKWARD:
                    begin
                        // negate inside 8 bits, so -128 stays -128
                        wrapped = -c.speed;
                        mot     = wrapped;
                    end
                    DIR_LEFT:
                    begin
                        mot = c.speed;
                        st  = 100;
                    end
                    DIR_RIGHT:
                    begin
                        mot = c.speed;
                        st  = -100;
                    end
                    default: ;
                endcase
            end
            FUNC_TICK: fresh = 1'b0;
            default: return 1'b0;
        endcase

        if (fresh)
        begin
            tgt_motor = limit_pm100(-mot);
            tgt_steer = limit_pm100(st);
            stop_repeats_left = (tgt_motor == 0 && tgt_steer == 0) ? resend_setting : 4'd0;
        end

        moving = (tgt_motor != 0) || (tgt_steer != 0);
        sends  = fresh || moving || (stop_repeats_left != 0);
        if (!moving && stop_repeats_left != 0)
            stop_repeats_left--;
        motor_b = tgt_motor;
        steer_b = tgt_steer;
        return sends;
    endfunction

    // Mostly short gaps, now and then a long one; none while no_idle holds.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic drive_cmd_t random_command();
        drive_cmd_t c;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 30) c.func = FUNC_DIFF;
        else if (r < 60) c.func = FUNC_DIR;
        else if (r < 95) c.func = FUNC_TICK;
        else c.func = FUNC_SPARE;
        c.left  = 8'($urandom);
        c.right = 8'($urandom);
        c.speed = 8'($urandom);
        // favor the named direction codes, keep the spare ones in play
        c.dir   = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                              : 3'($urandom_range(0, 4));
        return c;
    endfunction

    // A command that always sends: stop target from one of its several forms.
    function automatic drive_cmd_t stop_command();
        drive_cmd_t c;
        c = random_command();
        case ($urandom_range(0, 2))
            0:
            begin
                c.func  = FUNC_DIFF;
                c.left  = 8'sd0;
                c.right = 8'sd0;
            end
            1:
            begin
                c.func = FUNC_DIR;
                c.dir  = DIR_STOP;
            end
            default:
            begin
                c.func = FUNC_DIR;
                c.dir  = 3'($urandom_range(DIR_UNUSED_A, DIR_UNUSED_C));
            end
        endcase
        return c;
    endfunction

    task automatic note_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        mismatches++;
        $display("tb_top: mismatch at cycle %0d: %s got %02h want %02h",
                 cycle_count, what, got, want);
    endtask

    task automatic queue_frame(input logic [7:0] motor_b, input logic [7:0] steer_b);
        pending_bytes.push_back('{FRAME_HEAD, 1'b0});
        pending_bytes.push_back('{motor_b, 1'b0});
        pending_bytes.push_back('{steer_b, 1'b0});
        pending_bytes.push_back('{steer_b, 1'b0});
        pending_bytes.push_back('{FRAME_TAIL, 1'b1});
    endtask

    // Offer one command after a random gap, hold it until the transfer, then
    // queue the frame it is due to produce. Returns at the transfer edge.
    task automatic push_cmd(input drive_cmd_t c, input row_check_e chk,
                            input logic [7:0] given_motor, input logic [7:0] given_steer);
        int         gap;
        bit         sends;
        logic [7:0] m;
        logic [7:0] s;

        gap = gap_len();
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid <= 1'b1;
        cmd_ch.func  <= c.func;
        cmd_ch.left  <= c.left;
        cmd_ch.right <= c.right;
        cmd_ch.dir   <= c.dir;
        cmd_ch.speed <= c.speed;
        do
            @(posedge clk);
        while (cmd_ch.ready !== 1'b1);

        // The shadow state moves on every accepted item, typed rows included.
        sends = advance_drive_target(c, m, s);
        case (chk)
            CHECK_FRAME: queue_frame(given_motor, given_steer);
            CHECK_PREDICTED: if (sends) queue_frame(m, s);
            default: ;
        endcase
    endtask

    // Drop valid, wait until every queued byte has come out, then give a
    // silent item time to clear the input register.
    task automatic wait_frames_out();
        cmd_ch.valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write one register; the caller drops cfg_we after the last write.
    task automatic cfg_write(input logic [1:0] idx, input logic [6:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_STOP_RESEND: resend_setting = val[3:0];
            CFG_PIVOT_SPEED: pivot_setting  = val;
            CFG_STEER_GAIN:  gain_setting   = val[2:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Receiver: alternate bursts of ready with random stalls; on request,
    // hold ready low for a long stretch so the block backs up into cmd.
    initial
    begin
        int hold_left;
        int run_left;
        bit level;

        tx_ch.ready = 1'b0;
        hold_left   = 0;
        run_left    = 0;
        level       = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                tx_ch.ready <= 1'b0;
            end
            else if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES - 1;
                tx_ch.ready <= 1'b0;
            end
            else if (no_idle)
            begin
                tx_ch.ready <= 1'b1;
            end
            else
            begin
                if (run_left == 0)
                begin
                    level    = !level;
                    run_left = level ? $urandom_range(1, 30) : gap_len();
                    if (run_left == 0)
                    begin
                        level    = 1'b1;
                        run_left = $urandom_range(1, 30);
                    end
                end
                run_left--;
                tx_ch.ready <= level;
            end
        end
    end

    // Check every byte transfer against the oldest queued byte.
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && tx_ch.valid === 1'b1 && tx_ch.ready === 1'b1)
        begin
            if (pending_bytes.size() == 0)
            begin
                note_mismatch("byte with no frame pending", tx_ch.tx_byte, 8'h00);
            end
            else
            begin
                want = pending_bytes.pop_front();
                if (tx_ch.tx_byte !== want.data)
                    note_mismatch("tx_byte", tx_ch.tx_byte, want.data);
                if (tx_ch.frame_end !== want.last)
                    note_mismatch("frame_end", 8'(tx_ch.frame_end), 8'(want.last));
            end
        end
    end

    initial
    begin
        drive_cmd_t c;
        int         n;
        int         ticks;
        bit         mid_paused;

        cmd_ch.valid = 1'b0;
        cmd_ch.func  = FUNC_TICK;
        cmd_ch.left  = '0;
        cmd_ch.right = '0;
        cmd_ch.dir   = DIR_STOP;
        cmd_ch.speed = '0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_STOP_RESEND;
        cfg_data     = '0;
        mid_paused   = 1'b0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            push_cmd(directed_rows[i].cmd, directed_rows[i].check,
                     directed_rows[i].motor, directed_rows[i].steer);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            // Registers change only with the block idle.
            wait_frames_out();
            case (phase)
                0:
                begin
                    // all at the bottom: no stop resends, zero pivot, zero gain
                    cfg_write(CFG_STOP_RESEND, 7'd0);
                    cfg_write(CFG_PIVOT_SPEED, 7'd0);
                    cfg_write(CFG_STEER_GAIN, 7'd0);
                end
                1:
                begin
                    cfg_write(CFG_STOP_RESEND, 7'd15);
                    cfg_write(CFG_PIVOT_SPEED, 7'd100);
                    cfg_write(CFG_STEER_GAIN, 7'd7);
                end
                default:
                begin
                    cfg_write(CFG_STOP_RESEND, 7'($urandom_range(0, 15)));
                    cfg_write(CFG_PIVOT_SPEED, 7'($urandom_range(0, 100)));
                    cfg_write(CFG_STEER_GAIN, 7'($urandom_range(0, 7)));
                end
            endcase
            cfg_we <= 1'b0;

            if (phase == 2)
            begin
                // Stall the receiver and keep offering commands back to back
                // so the block fills and stops taking transfers on cmd.
                no_idle     = 1'b1;
                rx_hold_req = 1'b1;
                repeat (HOLD_BURST)
                begin
                    c = random_command();
                    c.func = ($urandom_range(0, 1) == 0) ? FUNC_DIFF : FUNC_DIR;
                    push_cmd(c, CHECK_PREDICTED, 8'h00, 8'h00);
                end
                no_idle = 1'b0;
            end

            // One phase runs with no idling on either side.
            no_idle = (phase == 4);
            n = 0;
            while (n < PHASE_ITEMS)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    // stop, then a run of ticks that walks the resend count
                    // down and past zero
                    push_cmd(stop_command(), CHECK_PREDICTED, 8'h00, 8'h00);
                    n++;
                    ticks = $urandom_range(1, 18);
                    repeat (ticks)
                    begin
                        c = random_command();
                        c.func = FUNC_TICK;
                        push_cmd(c, CHECK_PREDICTED, 8'h00, 8'h00);
                        n++;
                    end
                end
                else
                begin
                    c = random_command();
                    push_cmd(c, CHECK_PREDICTED, 8'h00, 8'h00);
                    if (c.func != FUNC_SPARE)
                        n++;
                end
                // Halfway through one phase, pause until the frames are out.
                if (phase == 5 && !mid_paused && n >= PHASE_ITEMS / 2)
                begin
                    mid_paused = 1'b1;
                    wait_frames_out();
                end
            end
            no_idle = 1'b0;
        end

        wait_frames_out();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+sv
sv/dcfr_pkg.sv
sv/dcfr_ifs.sv
sv/dcfr_mixer.sv
sv/dcfr_framer.sv
sv/drive_command_frame_refresher_unit.sv
tb/tb_top.sv
